### hw/rtl/fdx_pkg.sv
`default_nettype none
package fdx_pkg;

	typedef enum logic [1:0] {
		PH_HUNT  = 2'd0,
		PH_LEN   = 2'd1,
		PH_DATA  = 2'd2,
		PH_CHECK = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_PAYLOAD = 3'd1,
		EV_GOOD    = 3'd2,
		EV_BADSUM  = 3'd3,
		EV_BADLEN  = 3'd4,
		EV_IDLE    = 3'd5
	} event_t;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	localparam logic REG_HEADER     = 1'b0;
	localparam logic REG_IDLE_LIMIT = 1'b1;

	localparam logic [7:0]  HEADER_RESET     = 8'h0C;
	localparam logic [15:0] IDLE_LIMIT_RESET = 16'd1000;
	localparam logic [15:0] IDLE_MAX         = 16'hFFFF;

	localparam int unsigned QUEUE_DEPTH = 2;

	// An item after classification by the front end.
	typedef struct packed {
		logic       is_tick;
		logic [7:0] rx_byte;
		logic       hdr_hit;
		logic       len_ok;
	} cls_item_t;

endpackage
`default_nettype wire

### hw/rtl/fdx_if.sv
`default_nettype none
interface fdx_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] rx_byte;

	modport source (output valid, output kind, output rx_byte, input ready);
	modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

interface fdx_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_res;
	logic [7:0] payload_byte;
	logic [7:0] payload_index;
	logic [7:0] frame_length;

	modport source (
		output valid, output event_res, output payload_byte,
		output payload_index, output frame_length, input ready
	);
	modport sink (
		input valid, input event_res, input payload_byte,
		input payload_index, input frame_length, output ready
	);
endinterface
`default_nettype wire

### hw/rtl/fdx_front.sv
`default_nettype none
module fdx_front
	import fdx_pkg::*;
(
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       in_kind,
	input  wire logic [7:0] in_rx_byte,
	input  wire logic [7:0] header_byte,
	input  wire logic       q_full,
	output logic            push,
	output cls_item_t       push_item
);

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		push_item.is_tick = (in_kind == KIND_TICK);
		push_item.rx_byte = in_rx_byte;
		push_item.hdr_hit = (in_rx_byte == header_byte);
		push_item.len_ok  = (in_rx_byte > 8'd1);
	end

endmodule
`default_nettype wire

### hw/rtl/fdx_queue.sv
`default_nettype none
module fdx_queue
	import fdx_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire cls_item_t push_item,
	output logic           full,
	input  wire logic      pop,
	output logic           q_valid,
	output cls_item_t      pop_item
);

	localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

	cls_item_t         mem_q [QUEUE_DEPTH];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;

	assign full     = (count_q == CntW'(QUEUE_DEPTH));
	assign q_valid  = (count_q != '0);
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(QUEUE_DEPTH))
		else $error("queue count exceeds depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("pop from empty queue");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

endmodule
`default_nettype wire

### hw/rtl/fdx_back.sv
`default_nettype none
module fdx_back
	import fdx_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_valid,
	input  wire cls_item_t   q_item,
	output logic             pop,
	input  wire logic [15:0] idle_limit,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       out_event,
	output logic [7:0]       out_payload_byte,
	output logic [7:0]       out_payload_index,
	output logic [7:0]       out_frame_length
);

	phase_t      phase_q, phase_d;
	logic [7:0]  count_q, count_d;
	logic [7:0]  pos_q, pos_d;
	logic [7:0]  xor_q, xor_d;
	logic [15:0] idle_q, idle_d;

	logic        out_valid_q;
	event_t      ev_q, ev_d;
	logic [7:0]  pbyte_q, pbyte_d;
	logic [7:0]  pidx_q, pidx_d;
	logic [7:0]  flen_q, flen_d;

	logic [15:0] idle_inc;
	logic        idle_abort;
	logic [7:0]  pos_next;

	assign pop       = q_valid && (!out_valid_q || out_ready);
	assign idle_inc  = (idle_q == IDLE_MAX) ? idle_q : idle_q + 16'd1;
	assign idle_abort = (idle_inc >= idle_limit);
	assign pos_next  = pos_q + 8'd1;

	always_comb begin
		phase_d = phase_q;
		if (q_item.is_tick) begin
			if (phase_q != PH_HUNT && idle_abort) begin
				phase_d = PH_HUNT;
			end
		end else begin
			case (phase_q)
				PH_HUNT: begin
					if (q_item.hdr_hit) begin
						phase_d = PH_LEN;
					end
				end
				PH_LEN: begin
					phase_d = q_item.len_ok ? PH_DATA : PH_HUNT;
				end
				PH_DATA: begin
					if (pos_next >= count_q) begin
						phase_d = PH_CHECK;
					end
				end
				default: phase_d = PH_HUNT;
			endcase
		end
	end

	always_comb begin
		count_d = count_q;
		pos_d   = pos_q;
		xor_d   = xor_q;
		idle_d  = idle_q;
		ev_d    = EV_NONE;
		pbyte_d = '0;
		pidx_d  = '0;
		flen_d  = '0;
		if (q_item.is_tick) begin
			if (phase_q != PH_HUNT) begin
				idle_d = idle_inc;
				if (idle_abort) begin
					ev_d    = EV_IDLE;
					flen_d  = count_q;
					count_d = '0;
					pos_d   = '0;
					xor_d   = '0;
					idle_d  = '0;
				end
			end
		end else begin
			idle_d = '0;
			case (phase_q)
				PH_HUNT: begin
					if (q_item.hdr_hit) begin
						count_d = '0;
					end
				end
				PH_LEN: begin
					pos_d = '0;
					xor_d = '0;
					if (q_item.len_ok) begin
						count_d = q_item.rx_byte - 8'd1;
					end else begin
						ev_d    = EV_BADLEN;
						count_d = '0;
					end
				end
				PH_DATA: begin
					ev_d    = EV_PAYLOAD;
					pbyte_d = q_item.rx_byte;
					pidx_d  = pos_q;
					flen_d  = count_q;
					xor_d   = xor_q ^ q_item.rx_byte;
					pos_d   = pos_next;
				end
				default: begin
					ev_d    = (xor_q == q_item.rx_byte) ? EV_GOOD : EV_BADSUM;
					flen_d  = count_q;
					count_d = '0;
					pos_d   = '0;
					xor_d   = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			count_q     <= '0;
			pos_q       <= '0;
			xor_q       <= '0;
			idle_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= phase_d;
				count_q <= count_d;
				pos_q   <= pos_d;
				xor_q   <= xor_d;
				idle_q  <= idle_d;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ev_q    <= ev_d;
			pbyte_q <= pbyte_d;
			pidx_q  <= pidx_d;
			flen_q  <= flen_d;
		end
	end

	assign out_valid         = out_valid_q;
	assign out_event         = ev_q;
	assign out_payload_byte  = pbyte_q;
	assign out_payload_index = pidx_q;
	assign out_frame_length  = flen_q;

	a_hunt_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HUNT) |-> (idle_q == '0 && pos_q == '0 && xor_q == '0))
		else $error("frame state not cleared while hunting");

	a_data_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (pos_q < count_q))
		else $error("payload position beyond frame length");

	a_payload_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && ev_q != EV_PAYLOAD) |-> (pbyte_q == '0 && pidx_q == '0))
		else $error("payload fields set on a non-payload event");

	a_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LEN) |-> (count_q == '0))
		else $error("frame length set before the length byte");

endmodule
`default_nettype wire

### hw/rtl/frame_deframer_xor_check.sv
`default_nettype none
// Deframer for a byte stream of the form header, length (payload count plus one), payload,
// XOR checksum. Each input item, a received byte or an idle tick, yields exactly one result
// item: none, payload byte with its index, frame good, checksum bad, bad length or idle abort.
// A new item is accepted every cycle while the queue is not full; the front end classifies
// it against the header register and places it in a two-entry queue, and the back end
// updates the frame state into an output register whenever that register is empty or being
// taken, so the sustained rate is one item per cycle while the output is not stalled. An item
// is written into the queue when accepted, and its result is registered when it is popped.
// Register 0 is the header byte (reset 0x0C), register 1 the idle-tick limit (reset 1000);
// write them only while no item is in flight.
module frame_deframer_xor_check
	import fdx_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_wdata,
	fdx_in_if.sink           in_ch,
	fdx_out_if.source        out_ch
);

	logic [7:0]  header_q;
	logic [15:0] idle_limit_q;

	logic        q_full;
	logic        push;
	cls_item_t   push_item;
	logic        pop;
	logic        q_valid;
	cls_item_t   pop_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q     <= HEADER_RESET;
			idle_limit_q <= IDLE_LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEADER:     header_q     <= cfg_wdata[7:0];
				REG_IDLE_LIMIT: idle_limit_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	fdx_front u_front (
		.in_valid    (in_ch.valid),
		.in_ready    (in_ch.ready),
		.in_kind     (in_ch.kind),
		.in_rx_byte  (in_ch.rx_byte),
		.header_byte (header_q),
		.q_full      (q_full),
		.push        (push),
		.push_item   (push_item)
	);

	fdx_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.q_valid   (q_valid),
		.pop_item  (pop_item)
	);

	fdx_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_valid           (q_valid),
		.q_item            (pop_item),
		.pop               (pop),
		.idle_limit        (idle_limit_q),
		.out_valid         (out_ch.valid),
		.out_ready         (out_ch.ready),
		.out_event         (out_ch.event_res),
		.out_payload_byte  (out_ch.payload_byte),
		.out_payload_index (out_ch.payload_index),
		.out_frame_length  (out_ch.frame_length)
	);

endmodule
`default_nettype wire
